[hdl/swsum_pkg.sv]
// ============================================================================
// swsum_pkg
// Shared types and constants for the sorted weighted sum block.
// ============================================================================
package swsum_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;
    localparam int TOTAL_W = 64;
    localparam int PROD_W  = 2 * VALUE_W;

    typedef struct packed {
        logic signed [VALUE_W-1:0] perf_value;
        logic signed [VALUE_W-1:0] rank_weight;
        logic                      last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic        [RANK_W-1:0]  rank_index;
        logic signed [TOTAL_W-1:0] weighted_total;
        logic                      overflowed;
        logic                      last_result;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic load;
        logic accumulate;
    } t_mac_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_OUT_RD,
        S_OUT_MUL,
        S_OUT_ACC,
        S_OUT_EMIT
    } t_state;

endpackage

[hdl/swsum_if.sv]
// ============================================================================
// swsum_if
// Valid/ready channels for input and result beats.
// ============================================================================
interface swsum_in_if import swsum_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swsum_out_if import swsum_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/swsum_ram.sv]
// ============================================================================
// swsum_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module swsum_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/swsum_mac.sv]
// ============================================================================
// swsum_mac
// Registered multiply, wide accumulate and saturation to signed Q32.32.
// ============================================================================
module swsum_mac import swsum_pkg::*; #(
    parameter int ACC_W = 68
) (
    input  logic                      i_clk,
    input  t_mac_ctrl                 i_ctrl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_weight,
    output logic signed [TOTAL_W-1:0] o_total
);

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ACC_W-TOTAL_W:0]    acc_top;

    assign n_prod = i_value * i_weight;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.accumulate) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign acc_top = r_acc[ACC_W-1:TOTAL_W-1];

    always_comb begin
        priority if ((&acc_top) || !(|acc_top)) begin
            o_total = r_acc[TOTAL_W-1:0];
        end else if (acc_top[ACC_W-TOTAL_W]) begin
            o_total = {1'b1, {(TOTAL_W-1){1'b0}}};
        end else begin
            o_total = {1'b0, {(TOTAL_W-1){1'b1}}};
        end
    end

endmodule

[hdl/sorted_weighted_sum_top.sv]
// Load: one beat accepted per visit to idle; the value is then placed by insertion
//   into the sorted value RAM, with a read and a compare-write per shifted entry.
// Output: each result passes RAM read, multiply, accumulate and emit; emit waits
//   while the output is held. The value and weight RAMs share read address and enable.
// Reset: clears state, item count, drop flag and output valid; the RAMs keep
//   their contents and are only read where written in the current set.
// ============================================================================
// sorted_weighted_sum_top
// Ordered weighted sum: sorted insertion into RAM, then MAC pass.
// ============================================================================
module sorted_weighted_sum_top import swsum_pkg::*; #(
    parameter int MAX_ITEMS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swsum_in_if.sink      i_in,
    swsum_out_if.source   o_out
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int ACC_W = TOTAL_W + $clog2(MAX_ITEMS);

    t_state r_state, n_state;

    logic [CW-1:0]              r_count;
    logic                       r_drop;
    logic                       r_last;
    logic signed [VALUE_W-1:0]  r_key;
    logic [AW-1:0]              r_j;
    logic [AW-1:0]              r_k;
    logic                       r_out_valid;
    t_out_beat                  r_out;

    logic                 accept;
    logic                 has_room;
    logic                 out_free;
    logic                 is_last;
    logic                 key_less;

    logic                 val_we, val_re;
    logic [AW-1:0]        val_waddr, rd_addr;
    logic [VALUE_W-1:0]   val_wdata, val_rdata;
    logic                 wgt_we;
    logic [VALUE_W-1:0]   wgt_rdata;
    t_mac_ctrl            mac_ctrl;
    logic signed [TOTAL_W-1:0] total;

    assign accept   = i_in.valid && i_in.ready;
    assign has_room = r_count < CW'(MAX_ITEMS);
    assign out_free = !r_out_valid || o_out.ready;
    assign is_last  = (CW'(r_k) + CW'(1)) == r_count;
    assign key_less = $signed(val_rdata) > r_key;

    swsum_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS), .ADDR_W(AW)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    swsum_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS), .ADDR_W(AW)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (i_in.data.rank_weight),
        .i_re    (val_re),
        .i_raddr (rd_addr),
        .o_rdata (wgt_rdata)
    );

    swsum_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_value  ($signed(val_rdata)),
        .i_weight ($signed(wgt_rdata)),
        .o_total  (total)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (has_room) begin
                        n_state = S_INS_RD;
                    end else if (i_in.data.last_item) begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_j != '0) begin
                    n_state = S_INS_CMP;
                end else begin
                    n_state = r_last ? S_OUT_RD : S_IDLE;
                end
            end
            S_INS_CMP: begin
                if (key_less) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = r_last ? S_OUT_RD : S_IDLE;
                end
            end
            S_OUT_RD:  n_state = S_OUT_MUL;
            S_OUT_MUL: n_state = S_OUT_ACC;
            S_OUT_ACC: n_state = S_OUT_EMIT;
            S_OUT_EMIT: begin
                if (out_free) begin
                    n_state = is_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = 1'b0;
        val_we     = 1'b0;
        val_waddr  = r_j;
        val_wdata  = r_key;
        val_re     = 1'b0;
        rd_addr    = r_k;
        wgt_we     = 1'b0;
        mac_ctrl   = '0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                wgt_we     = i_in.valid && has_room;
            end
            S_INS_RD: begin
                if (r_j != '0) begin
                    val_re  = 1'b1;
                    rd_addr = r_j - AW'(1);
                end else begin
                    val_we  = 1'b1;
                end
            end
            S_INS_CMP: begin
                val_we = 1'b1;
                if (key_less) begin
                    val_wdata = val_rdata;
                end
            end
            S_OUT_RD: begin
                val_re         = 1'b1;
                mac_ctrl.clear = (r_k == '0);
            end
            S_OUT_MUL:  mac_ctrl.load       = 1'b1;
            S_OUT_ACC:  mac_ctrl.accumulate = 1'b1;
            S_OUT_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && accept) begin
                r_last <= i_in.data.last_item;
                r_k    <= '0;
                if (has_room) begin
                    r_key   <= i_in.data.perf_value;
                    r_j     <= AW'(r_count);
                    r_count <= r_count + CW'(1);
                end else begin
                    r_drop  <= 1'b1;
                end
            end
            if (r_state == S_INS_CMP && key_less) begin
                r_j <= r_j - AW'(1);
            end
            if (r_state == S_OUT_EMIT && out_free) begin
                r_out_valid               <= 1'b1;
                r_out.sorted_value        <= $signed(val_rdata);
                r_out.rank_index          <= RANK_W'(r_k);
                r_out.weighted_total      <= is_last ? total : '0;
                r_out.overflowed          <= r_drop;
                r_out.last_result         <= is_last;
                r_k                       <= r_k + AW'(1);
                if (is_last) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
